[src/ckp_pkg.sv]
// ckp_pkg: shared constants, beat types and character codes for the cookie pair parser.
// No dependencies; imported by ckp_core and cookie_pair_parser.
`default_nettype none

package ckp_pkg;

   // Saturation limit for offsets, lengths and the byte position
   localparam int unsigned MAX_LEN = 1024;
   localparam int unsigned POS_W   = $clog2(MAX_LEN + 1);  // holds 0..MAX_LEN
   localparam int unsigned OFS_W   = $clog2(MAX_LEN);      // holds 0..MAX_LEN-1

   // Fixed result field widths
   localparam int unsigned START_W  = 10;
   localparam int unsigned LENGTH_W = 11;

   // Character codes
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_EQUAL = 8'h3D;
   localparam logic [7:0] CH_SEMI  = 8'h3B;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic                pair_valid;
      logic [START_W-1:0]  key_start;
      logic [LENGTH_W-1:0] key_length;
      logic [START_W-1:0]  value_start;
      logic [LENGTH_W-1:0] value_length;
      logic                end_of_string;
      logic                malformed;
   } rsp_type;

endpackage

`default_nettype wire

[src/ckp_core.sv]
// ckp_core: parse state machine; consumes one byte per step and forms the result.
// Depends on ckp_pkg.
`default_nettype none

module ckp_core
   import ckp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    step,      // consume req this cycle
   input  wire req_type req,
   output logic         produced,  // step yields a result beat
   output rsp_type      rsp
);

   typedef enum logic [2:0] {
      PH_BEFORE_KEY,
      PH_KEY,
      PH_BEFORE_VALUE,
      PH_VALUE,
      PH_ERROR
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [OFS_W-1:0]  key_ofs_ff, key_ofs_in;
   logic [POS_W-1:0]  key_cnt_ff, key_cnt_in;
   logic [OFS_W-1:0]  val_ofs_ff, val_ofs_in;
   logic [POS_W-1:0]  val_cnt_ff, val_cnt_in;

   logic              blank;
   logic              ends;
   logic [OFS_W-1:0]  off;

   function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
      if (v < POS_W'(MAX_LEN)) begin
         sat_inc = v + POS_W'(1);
      end else begin
         sat_inc = POS_W'(MAX_LEN);
      end
   endfunction

   always_comb begin
      blank = (req.data_byte == CH_SPACE) || (req.data_byte == CH_TAB);
      ends  = (req.data_byte == CH_NUL) || req.last_byte;
      if (pos_ff < POS_W'(MAX_LEN - 1)) begin
         off = OFS_W'(pos_ff);
      end else begin
         off = OFS_W'(MAX_LEN - 1);
      end

      phase_in   = phase_ff;
      pos_in     = pos_ff;
      key_ofs_in = key_ofs_ff;
      key_cnt_in = key_cnt_ff;
      val_ofs_in = val_ofs_ff;
      val_cnt_in = val_cnt_ff;
      produced   = 1'b0;
      rsp        = '0;

      if (req.data_byte != CH_NUL) begin
         case (phase_ff)
            PH_BEFORE_KEY: begin
               if (blank) begin
                  phase_in = PH_BEFORE_KEY;
               end else if (req.data_byte == CH_EQUAL) begin
                  phase_in = PH_ERROR;
               end else begin
                  key_ofs_in = off;
                  key_cnt_in = POS_W'(1);
                  phase_in   = PH_KEY;
               end
            end
            PH_KEY: begin
               if (req.data_byte == CH_EQUAL) begin
                  phase_in = PH_BEFORE_VALUE;
               end else begin
                  key_cnt_in = sat_inc(key_cnt_ff);
               end
            end
            PH_BEFORE_VALUE: begin
               if (blank) begin
                  phase_in = PH_BEFORE_VALUE;
               end else if (req.data_byte == CH_SEMI) begin
                  phase_in = PH_ERROR;
               end else begin
                  val_ofs_in = off;
                  val_cnt_in = POS_W'(1);
                  phase_in   = PH_VALUE;
               end
            end
            PH_VALUE: begin
               if (req.data_byte == CH_SEMI) begin
                  produced = 1'b1;
                  phase_in = PH_BEFORE_KEY;
               end else begin
                  val_cnt_in = sat_inc(val_cnt_ff);
               end
            end
            default: begin
               phase_in = PH_ERROR;
            end
         endcase
         pos_in = sat_inc(pos_ff);
      end

      // a pair closes on ';' or on end of string inside a value
      if (produced || (ends && phase_in == PH_VALUE)) begin
         rsp.pair_valid   = 1'b1;
         rsp.key_start    = START_W'(key_ofs_in);
         rsp.key_length   = LENGTH_W'(key_cnt_in);
         rsp.value_start  = START_W'(val_ofs_in);
         rsp.value_length = LENGTH_W'(val_cnt_in);
      end

      if (ends) begin
         produced          = 1'b1;
         rsp.end_of_string = 1'b1;
         rsp.malformed     = (phase_in != PH_VALUE) && (phase_in != PH_BEFORE_KEY);
         phase_in          = PH_BEFORE_KEY;
         pos_in            = '0;
         key_ofs_in        = '0;
         key_cnt_in        = '0;
         val_ofs_in        = '0;
         val_cnt_in        = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_BEFORE_KEY;
         pos_ff     <= '0;
         key_ofs_ff <= '0;
         key_cnt_ff <= '0;
         val_ofs_ff <= '0;
         val_cnt_ff <= '0;
      end else if (step) begin
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         key_ofs_ff <= key_ofs_in;
         key_cnt_ff <= key_cnt_in;
         val_ofs_ff <= val_ofs_in;
         val_cnt_ff <= val_cnt_in;
      end
   end

endmodule

`default_nettype wire

[src/cookie_pair_parser.sv]
// cookie_pair_parser: top level; input beat register, parse core, result register.
// Depends on ckp_pkg and ckp_core.
//
//   channel  ports                           dir  carries
//   -------  ------------------------------  ---  ------------------------------------
//   req      req_valid req_stall req_data    in   one string byte + last flag per beat
//   rsp      rsp_valid rsp_stall rsp_data    out  pair and/or end-of-string report
//
// Flow: one byte per clock sustained while rsp_stall is low; each accepted byte is held
// in the input register, then its result in the result register. The parse state
// update is one compare-and-increment step on the byte held in the input register.
// Reset: synchronous, active high; clears both valid flags and the parse state.
// Stalls: rsp_stall holds the result register; the input register then holds too and
// req_stall rises only while it is full and cannot drain.
`default_nettype none

module cookie_pair_parser
   import ckp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,

   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,

   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   // input beat register
   logic    in_valid_ff;
   req_type in_data_ff;

   // result register
   logic    out_valid_ff;
   rsp_type out_data_ff;

   logic    out_free;
   logic    advance;
   logic    produced;
   rsp_type result;

   // result register can take a beat if empty or draining this cycle
   assign out_free  = !out_valid_ff || !rsp_stall;
   // byte in the input register is parsed when its result has somewhere to go;
   // bytes with no result advance on the same condition to keep order simple
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   ckp_core u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .req      (in_data_ff),
      .produced (produced),
      .rsp      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (!req_stall && req_valid) begin
         in_data_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= advance && produced;
      end
      if (out_free && advance && produced) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // ---- assertions ----

   // a reported pair always has a nonempty key and value
   a_pair_nonempty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.pair_valid) |->
         (rsp_data.key_length != '0) && (rsp_data.value_length != '0))
      else $error("pair with empty key or value");

   // malformed only rides on the end-of-string beat
   a_malformed_at_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.malformed) |-> rsp_data.end_of_string)
      else $error("malformed without end of string");

   // every beat carries a pair or closes the string
   a_beat_has_content: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.pair_valid || rsp_data.end_of_string))
      else $error("empty result beat");

   // input side stalls only while the result side is blocked
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without output backpressure");

endmodule

`default_nettype wire
